// ===== design/rgp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types, constants and step functions of the radial gradient pipeline.
// ----------------------------------------------------------------------------
package rgp_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 12;
  localparam int COLOR_W    = 8;
  localparam int RAD_W      = 42;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int RATIO_W    = 17;
  localparam int DIV_STAGES = RATIO_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COL_COUNT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_RED   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_GREEN = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTER_BLUE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CORNER_RED   = 3'd5;
  localparam logic [IDX_W-1:0] REG_CORNER_GREEN = 3'd6;
  localparam logic [IDX_W-1:0] REG_CORNER_BLUE  = 3'd7;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [RAD_W-1:0] n;
    logic [RAD_W-1:0] root;
  } sqrt_state_t;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [RATIO_W-1:0] quo;
    logic [ROOT_W-1:0]  half;
    logic               sat;
  } div_state_t;

  function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [RAD_W-1:0] one_v);
    sqrt_state_t      r;
    logic [RAD_W-1:0] t;
    t = s.root + one_v;
    if (s.n >= t) begin
      r.n    = s.n - t;
      r.root = (s.root >> 1) + one_v;
    end else begin
      r.n    = s.n;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  function automatic div_state_t div_step(div_state_t s, logic first);
    div_state_t       r;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] h;
    r = s;
    h = {1'b0, s.half};
    t = first ? s.rem : {s.rem[REM_W-2:0], 1'b0};
    if (t >= h) begin
      r.rem = t - h;
      r.quo = {s.quo[RATIO_W-2:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {s.quo[RATIO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] mix(logic [COLOR_W-1:0] center,
                                             logic [COLOR_W-1:0] corner,
                                             logic [RATIO_W-1:0] ratio);
    logic [COLOR_W-1:0]         diff;
    logic [COLOR_W+RATIO_W-1:0] prod;
    logic [COLOR_W-1:0]         step;
    diff = (corner >= center) ? corner - center : center - corner;
    prod = {{RATIO_W{1'b0}}, diff} * {{COLOR_W{1'b0}}, ratio};
    step = prod[COLOR_W+15:16];
    return (corner >= center) ? center + step : center - step;
  endfunction

endpackage

// ===== design/rgp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_front
// Squares the center offsets and the image size into the two radicands.
// ----------------------------------------------------------------------------
module rgp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rgp_pkg::DIM_W-1:0]  row_count,
  input  logic [rgp_pkg::DIM_W-1:0]  col_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rgp_pkg::PIX_W-1:0]  pixel_row,
  input  logic [rgp_pkg::PIX_W-1:0]  pixel_col,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rgp_pkg::RAD_W-1:0]  rad_dist,
  output logic [rgp_pkg::RAD_W-1:0]  rad_half
);
  import rgp_pkg::*;

  logic [DIM_W-1:0]   nr;
  logic [DIM_W-1:0]   nc;
  logic [DIM_W-1:0]   cr;
  logic [DIM_W-1:0]   cc;
  logic [DIM_W-1:0]   adr;
  logic [DIM_W-1:0]   adc;
  logic [2*DIM_W:0]   sum_d;
  logic [2*DIM_W:0]   sum_h;

  always_comb begin
    nr = (row_count == '0) ? DIM_W'(1) :
         (row_count > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : row_count;
    nc = (col_count == '0) ? DIM_W'(1) :
         (col_count > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : col_count;
    cr = nr >> 1;
    cc = nc >> 1;
    adr = ({1'b0, pixel_row} >= cr) ? {1'b0, pixel_row} - cr : cr - {1'b0, pixel_row};
    adc = ({1'b0, pixel_col} >= cc) ? {1'b0, pixel_col} - cc : cc - {1'b0, pixel_col};
    sum_d = (2*DIM_W+1)'(adr * adr) + (2*DIM_W+1)'(adc * adc);
    sum_h = (2*DIM_W+1)'(nr * nr) + (2*DIM_W+1)'(nc * nc);
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rad_dist <= RAD_W'({sum_d, 16'd0});
      rad_half <= RAD_W'({sum_h, 14'd0});
    end
  end

endmodule

// ===== design/rgp_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_sqrt_pipe
// Two-lane integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module rgp_sqrt_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rgp_pkg::RAD_W-1:0]   n_a,
  input  logic [rgp_pkg::RAD_W-1:0]   n_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgp_pkg::ROOT_W-1:0]  root_a,
  output logic [rgp_pkg::ROOT_W-1:0]  root_b
);
  import rgp_pkg::*;

  logic [SQ_STAGES-1:0] v;
  logic [SQ_STAGES-1:0] src_v;
  logic [SQ_STAGES:0]   rdy;
  sqrt_state_t          sa     [SQ_STAGES];
  sqrt_state_t          sb     [SQ_STAGES];
  sqrt_state_t          src_a  [SQ_STAGES];
  sqrt_state_t          src_b  [SQ_STAGES];

  assign rdy[SQ_STAGES] = out_ready;
  assign in_ready       = rdy[0];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [RAD_W-1:0] ONE_V = RAD_W'(1) << (2 * (SQ_STAGES - 1 - k));

    if (k == 0) begin : g_first
      assign src_v[k] = in_valid;
      assign src_a[k] = '{n: n_a, root: '0};
      assign src_b[k] = '{n: n_b, root: '0};
    end else begin : g_rest
      assign src_v[k] = v[k-1];
      assign src_a[k] = sa[k-1];
      assign src_b[k] = sb[k-1];
    end

    assign rdy[k] = ~v[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) begin
        sa[k] <= sqrt_step(src_a[k], ONE_V);
        sb[k] <= sqrt_step(src_b[k], ONE_V);
      end
    end
  end

  assign out_valid = v[SQ_STAGES-1];
  assign root_a    = sa[SQ_STAGES-1].root[ROOT_W-1:0];
  assign root_b    = sb[SQ_STAGES-1].root[ROOT_W-1:0];

endmodule

// ===== design/rgp_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgp_div_pipe
// Restoring divider for distance over half diagonal, saturating at one.
// ----------------------------------------------------------------------------
module rgp_div_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rgp_pkg::ROOT_W-1:0]   dist_root,
  input  logic [rgp_pkg::ROOT_W-1:0]   half,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgp_pkg::RATIO_W-1:0]  ratio
);
  import rgp_pkg::*;

  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES-1:0] src_v;
  logic [DIV_STAGES:0]   rdy;
  div_state_t            st   [DIV_STAGES];
  div_state_t            src  [DIV_STAGES];
  div_state_t            last;

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src_v[k] = in_valid;
      assign src[k]   = '{rem: {1'b0, dist_root}, quo: '0, half: half,
                          sat: ({1'b0, dist_root} >= {half, 1'b0})};
    end else begin : g_rest
      assign src_v[k] = v[k-1];
      assign src[k]   = st[k-1];
    end

    assign rdy[k] = ~v[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) begin
        st[k] <= div_step(src[k], (k == 0));
      end
    end
  end

  assign last      = st[DIV_STAGES-1];
  assign out_valid = v[DIV_STAGES-1];
  assign ratio     = (last.sat || last.quo > RATIO_ONE) ? RATIO_ONE : last.quo;

endmodule

// ===== design/radial_gradient_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_gradient_pixel
// Radial gradient color for one pixel coordinate per request.
//
// A request on in_valid/in_ready carries pixel_row and pixel_col; the result
// on out_valid/out_ready carries red_out, green_out and blue_out, in request
// order. Image size and the center and corner colors are set through the
// write port (wr_en, wr_index, wr_data); write them only while no request
// is in flight, which the block does not enforce. One stage forms the squared
// radicands, 21 stages of the square root unit give one root bit each, 17
// divider stages give one ratio bit each, and the output register applies
// the color blend. One request is taken every cycle unless the receiver stalls.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so a stalled receiver fills the empty stages first and
// then holds in_ready low; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and sets the registers to a 1 by 1
// image with all colors black.
// ----------------------------------------------------------------------------
module radial_gradient_pixel (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [rgp_pkg::IDX_W-1:0]    wr_index,
  input  logic [rgp_pkg::DIM_W-1:0]    wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rgp_pkg::PIX_W-1:0]    pixel_row,
  input  logic [rgp_pkg::PIX_W-1:0]    pixel_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgp_pkg::COLOR_W-1:0]  red_out,
  output logic [rgp_pkg::COLOR_W-1:0]  green_out,
  output logic [rgp_pkg::COLOR_W-1:0]  blue_out
);
  import rgp_pkg::*;

  logic [DIM_W-1:0]   row_count;
  logic [DIM_W-1:0]   col_count;
  rgb_t               center;
  rgb_t               corner;

  logic               fr_valid;
  logic               fr_ready;
  logic [RAD_W-1:0]   rad_dist;
  logic [RAD_W-1:0]   rad_half;
  logic               sq_valid;
  logic               sq_ready;
  logic [ROOT_W-1:0]  dist_root;
  logic [ROOT_W-1:0]  half;
  logic               dv_valid;
  logic               dv_ready;
  logic [RATIO_W-1:0] ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_W'(1);
      col_count <= DIM_W'(1);
      center    <= '0;
      corner    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROW_COUNT:    row_count    <= wr_data;
        REG_COL_COUNT:    col_count    <= wr_data;
        REG_CENTER_RED:   center.red   <= wr_data[COLOR_W-1:0];
        REG_CENTER_GREEN: center.green <= wr_data[COLOR_W-1:0];
        REG_CENTER_BLUE:  center.blue  <= wr_data[COLOR_W-1:0];
        REG_CORNER_RED:   corner.red   <= wr_data[COLOR_W-1:0];
        REG_CORNER_GREEN: corner.green <= wr_data[COLOR_W-1:0];
        REG_CORNER_BLUE:  corner.blue  <= wr_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  rgp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .row_count (row_count),
    .col_count (col_count),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_row (pixel_row),
    .pixel_col (pixel_col),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .rad_dist  (rad_dist),
    .rad_half  (rad_half)
  );

  rgp_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .n_a       (rad_dist),
    .n_b       (rad_half),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .root_a    (dist_root),
    .root_b    (half)
  );

  rgp_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .dist_root (dist_root),
    .half      (half),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .ratio     (ratio)
  );

  assign dv_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dv_ready) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready && dv_valid) begin
      red_out   <= mix(center.red, corner.red, ratio);
      green_out <= mix(center.green, corner.green, ratio);
      blue_out  <= mix(center.blue, corner.blue, ratio);
    end
  end

endmodule

// ===== tb/sv/radial_gradient_pixel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_gradient_pixel_tb
// Self-checking bench for the radial gradient pixel pipeline. A predictor
// computes each pixel color from the image size and the center and corner
// colors; results are matched in order, field by field. Directed requests
// cover dimension extremes, clamped dimensions and outside pixels; random
// requests run under random sender and receiver stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module radial_gradient_pixel_tb;
  import rgp_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_index;
  logic [DIM_W-1:0]     wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel_row;
  logic [PIX_W-1:0]     pixel_col;
  logic                 out_valid;
  logic                 out_ready;
  logic [COLOR_W-1:0]   red_out;
  logic [COLOR_W-1:0]   green_out;
  logic [COLOR_W-1:0]   blue_out;

  logic [DIM_W-1:0]     img_rows;
  logic [DIM_W-1:0]     img_cols;
  logic [COLOR_W-1:0]   center_rgb [3];
  logic [COLOR_W-1:0]   corner_rgb [3];
  rgb_t                 color_queue [$];
  int                   error_count;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   hold_left;

  radial_gradient_pixel uut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_row(pixel_row),
    .pixel_col(pixel_col), .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [COLOR_W-1:0] blend(logic [COLOR_W-1:0] ctr,
                                               logic [COLOR_W-1:0] cor,
                                               longint unsigned ratio);
    longint unsigned delta;
    if (cor >= ctr) begin
      delta = ((cor - ctr) * ratio) >> 16;
      return ctr + delta[COLOR_W-1:0];
    end
    delta = ((ctr - cor) * ratio) >> 16;
    return ctr - delta[COLOR_W-1:0];
  endfunction

  function automatic rgb_t pixel_color(logic [PIX_W-1:0] r, logic [PIX_W-1:0] c);
    longint unsigned nr, nc, cr, cc, dr, dc, dist_q, half, ratio;
    rgb_t res;
    nr = eff_dim(img_rows);
    nc = eff_dim(img_cols);
    cr = nr / 2;
    cc = nc / 2;
    dr = (r >= cr) ? r - cr : cr - r;
    dc = (c >= cc) ? c - cc : cc - c;
    dist_q = int_sqrt((dr * dr + dc * dc) << 16);
    half = int_sqrt((nr * nr + nc * nc) << 14);
    if (half == 0) half = 1;
    ratio = (dist_q << 16) / half;
    if (ratio > 65536) ratio = 65536;
    res.red   = blend(center_rgb[0], corner_rgb[0], ratio);
    res.green = blend(center_rgb[1], corner_rgb[1], ratio);
    res.blue  = blend(center_rgb[2], corner_rgb[2], ratio);
    return res;
  endfunction

  // receiver with random stalls and a counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && out_ready) begin
      if (color_queue.size() == 0) begin
        $display("%0t: unexpected color %h %h %h", $time, red_out, green_out, blue_out);
        error_count++;
      end else begin
        want = color_queue.pop_front();
        if (red_out !== want.red) begin
          $display("%0t: red expected %h actual %h", $time, want.red, red_out);
          error_count++;
        end
        if (green_out !== want.green) begin
          $display("%0t: green expected %h actual %h", $time, want.green, green_out);
          error_count++;
        end
        if (blue_out !== want.blue) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, blue_out);
          error_count++;
        end
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel_row <= r;
    pixel_col <= c;
    do @(posedge clk); while (!in_ready);
    color_queue.push_back(pixel_color(r, c));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en    <= 1'b0;
    case (idx)
      REG_ROW_COUNT:    img_rows = val;
      REG_COL_COUNT:    img_cols = val;
      REG_CENTER_RED:   center_rgb[0] = val[7:0];
      REG_CENTER_GREEN: center_rgb[1] = val[7:0];
      REG_CENTER_BLUE:  center_rgb[2] = val[7:0];
      REG_CORNER_RED:   corner_rgb[0] = val[7:0];
      REG_CORNER_GREEN: corner_rgb[1] = val[7:0];
      default:          corner_rgb[2] = val[7:0];
    endcase
  endtask

  task automatic set_image(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                           logic [DIM_W-1:0] cr, logic [DIM_W-1:0] cg,
                           logic [DIM_W-1:0] cb, logic [DIM_W-1:0] kr,
                           logic [DIM_W-1:0] kg, logic [DIM_W-1:0] kb);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_CENTER_RED, cr);
    write_reg(REG_CENTER_GREEN, cg);
    write_reg(REG_CENTER_BLUE, cb);
    write_reg(REG_CORNER_RED, kr);
    write_reg(REG_CORNER_GREEN, kg);
    write_reg(REG_CORNER_BLUE, kb);
  endtask

  task automatic test_reset_defaults;
    send_pixel(0, 0);
    send_pixel(12'hfff, 12'hfff);
    drain();
  endtask

  task automatic test_full_size;
    set_image(4096, 4096, 0, 128, 255, 255, 127, 0);
    send_pixel(2048, 2048);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(2048, 3000);
    send_pixel(12'haaa, 12'h555);
    drain();
  endtask

  task automatic test_clamped_dims;
    set_image(0, 8191, 255, 0, 17, 0, 255, 200);
    send_pixel(0, 2048);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(12'h555, 12'haaa);
    drain();
    set_image(4097, 1, 8191, 40, 90, 7, 240, 90);
    send_pixel(2048, 0);
    send_pixel(100, 0);
    send_pixel(4095, 4095);
    drain();
  endtask

  task automatic test_outside_pixels;
    set_image(3, 5, 10, 200, 99, 250, 20, 99);
    send_pixel(1, 2);
    send_pixel(0, 0);
    send_pixel(2, 4);
    send_pixel(3, 5);
    send_pixel(4095, 4095);
    send_pixel(1, 3000);
    drain();
  endtask

  task automatic test_random(int count, bit long_hold);
    logic [DIM_W-1:0] rows, cols;
    logic [PIX_W-1:0] r, c;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        drain();
        case ($urandom_range(5))
          0: begin
            rows = DIM_W'($urandom_range(8191));
            cols = DIM_W'($urandom_range(8191));
          end
          1: begin
            rows = DIM_W'(4096);
            cols = DIM_W'($urandom_range(4096, 1));
          end
          default: begin
            rows = DIM_W'($urandom_range(64, 1));
            cols = DIM_W'($urandom_range(64, 1));
          end
        endcase
        set_image(rows, cols, DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                  DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
        if (long_hold && i == 0) hold_left = 400;
      end
      if ($urandom_range(9) < 7) begin
        r = PIX_W'($urandom_range(32'(eff_dim(img_rows) - 1)));
        c = PIX_W'($urandom_range(32'(eff_dim(img_cols) - 1)));
      end else begin
        r = PIX_W'($urandom);
        c = PIX_W'($urandom);
      end
      send_pixel(r, c);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    pixel_row = '0;
    pixel_col = '0;
    hold_left = 0;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    img_rows = 1;
    img_cols = 1;
    for (int k = 0; k < 3; k++) begin
      center_rgb[k] = '0;
      corner_rgb[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_size();
    test_clamped_dims();
    test_outside_pixels();
    send_idle_pct = 21;
    recv_idle_pct = 47;
    test_random(240, 1'b0);
    send_idle_pct = 47;
    recv_idle_pct = 21;
    test_random(240, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(240, 1'b1);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
